>>> hw/rtl/chc_pkg.sv
`default_nettype none

package chc_pkg;

  localparam int NUM_SYMBOLS_DEF = 30;
  localparam int MAX_LEN_DEF     = 16;

  localparam int SYM_W  = 5;
  localparam int LEN_W  = 4;
  localparam int CODE_W = 15;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_HIST,
    ST_PREF,
    ST_EMIT
  } phase_t;

  // access bundle for the count / next-code table
  typedef struct packed {
    logic              rd_en;
    logic [LEN_W-1:0]  rd_addr;
    logic              wr_en;
    logic [LEN_W-1:0]  wr_addr;
    logic [CODE_W-1:0] wr_data;
    logic              clr;
  } tab_req_t;

endpackage

`default_nettype wire

>>> hw/rtl/chc_in_if.sv
`default_nettype none

interface chc_in_if;
  logic                       valid;
  logic                       ready;
  logic [chc_pkg::SYM_W-1:0]  symbol;
  logic [chc_pkg::LEN_W-1:0]  code_length;
  logic                       last;

  modport source (output valid, output symbol, output code_length, output last, input ready);
  modport sink   (input valid, input symbol, input code_length, input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/chc_out_if.sv
`default_nettype none

interface chc_out_if;
  logic                        valid;
  logic                        ready;
  logic [chc_pkg::SYM_W-1:0]   out_symbol;
  logic [chc_pkg::CODE_W-1:0]  code_bits;
  logic [chc_pkg::LEN_W-1:0]   out_length;
  logic                        final_item;

  modport source (output valid, output out_symbol, output code_bits, output out_length,
                  output final_item, input ready);
  modport sink   (input valid, input out_symbol, input code_bits, input out_length,
                  input final_item, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/chc_tab.sv
`default_nettype none

// Per-length table: holds symbol counts, later the next code of each length.
// Entries read as zero until written; clr drops all entries at once.
module chc_tab #(
  parameter int MAX_LEN = chc_pkg::MAX_LEN_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire chc_pkg::tab_req_t           req,
  output      logic [chc_pkg::CODE_W-1:0]  rd_data
);

  localparam int LW = $clog2(MAX_LEN);

  logic [chc_pkg::CODE_W-1:0] mem [MAX_LEN];
  logic [MAX_LEN-1:0]         vld_r;
  logic [chc_pkg::CODE_W-1:0] q_r;
  logic                       qv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      if (req.rd_en) begin
        qv_r <= vld_r[req.rd_addr[LW-1:0]];
      end
      if (req.clr) begin
        vld_r <= '0;
      end else if (req.wr_en) begin
        vld_r[req.wr_addr[LW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      q_r <= mem[req.rd_addr[LW-1:0]];
    end
    if (req.wr_en) begin
      mem[req.wr_addr[LW-1:0]] <= req.wr_data;
    end
  end

  assign rd_data = qv_r ? q_r : '0;

endmodule

`default_nettype wire

>>> hw/rtl/canonical_huffman_code_assign.sv
`default_nettype none

// Canonical Huffman code assignment (DEFLATE rule). Each accepted item whose
// symbol is below NUM_SYMBOLS writes that symbol's code length into the length
// memory. An item with last set starts the build. First comes a histogram sweep
// over the length memory, with one read-modify-write of the count table per
// cycle. Next a prefix pass turns the counts into first codes. Last, an
// emission sweep hands out codes in symbol order, then both memories are
// cleared. The single read port of the count table sets the pace of the
// histogram sweep. No item is accepted during the build. Results come out one
// per symbol, with final_item set on the last.
module canonical_huffman_code_assign #(
  parameter int NUM_SYMBOLS = chc_pkg::NUM_SYMBOLS_DEF,
  parameter int MAX_LEN     = chc_pkg::MAX_LEN_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  chc_in_if.sink     in_ch,
  chc_out_if.source  out_ch
);

  localparam int SW    = $clog2(NUM_SYMBOLS);
  localparam int KW    = $clog2(NUM_SYMBOLS + 1);
  localparam int LW    = $clog2(MAX_LEN);
  localparam int LEN_W = chc_pkg::LEN_W;
  localparam int CW    = chc_pkg::CODE_W;

  chc_pkg::phase_t   state_r, state_nxt;
  chc_pkg::tab_req_t tab_req;
  logic [CW-1:0]     tab_q;

  // length memory
  logic [LEN_W-1:0]       st_mem [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] st_vld_r;
  logic [LEN_W-1:0]       st_q_r;
  logic                   st_qv_r;

  // sweep pipeline
  logic [KW-1:0]    k_r;
  logic             a_v_r, b_v_r;
  logic [SW-1:0]    a_k_r, b_k_r;
  logic [LEN_W-1:0] b_l_r;
  logic             lw_en_r;
  logic [LEN_W-1:0] lw_addr_r;
  logic [CW-1:0]    lw_data_r;

  // prefix pass
  logic [LW-1:0] j_r, p_j_r, p_j_inc;
  logic          p_v_r;
  logic [CW-1:0] code_r, pref_sum, pref_code;

  // result register
  logic             out_valid_r;
  logic [SW-1:0]    out_k_r;
  logic [CW-1:0]    out_code_r;
  logic [LEN_W-1:0] out_len_r;
  logic             out_final_r;

  logic             in_fire, sym_ok, len_ok, ld_en;
  logic [6:0]       sym_ext, out_sym_ext;
  logic [SW-1:0]    ld_idx;
  logic [LEN_W-1:0] ld_len, st_q;
  logic             sweep, adv, issue, sweep_wr, sweep_done, out_load;
  logic             pref_issue, pref_done, phase_chg;
  logic [CW-1:0]    tab_d, tab_inc;

  chc_tab #(.MAX_LEN(MAX_LEN)) u_tab (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (tab_req),
    .rd_data (tab_q)
  );

  assign in_ch.ready = (state_r == chc_pkg::ST_LOAD);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign sym_ext     = 7'(in_ch.symbol);
  assign sym_ok      = sym_ext < 7'(NUM_SYMBOLS);
  assign ld_idx      = sym_ext[SW-1:0];
  assign len_ok      = {1'b0, in_ch.code_length} < 5'(MAX_LEN);
  assign ld_len      = len_ok ? in_ch.code_length : '0;
  assign ld_en       = in_fire && sym_ok;

  assign sweep = (state_r == chc_pkg::ST_HIST) || (state_r == chc_pkg::ST_EMIT);
  assign adv   = (state_r == chc_pkg::ST_HIST) ||
                 ((state_r == chc_pkg::ST_EMIT) && (!out_valid_r || out_ch.ready));
  assign issue = sweep && adv && (k_r < KW'(NUM_SYMBOLS));
  assign st_q  = st_qv_r ? st_q_r : '0;

  // the table read was issued on the edge of the previous write; forward it
  assign tab_d      = (lw_en_r && (lw_addr_r == b_l_r)) ? lw_data_r : tab_q;
  assign tab_inc    = tab_d + CW'(1);
  assign sweep_wr   = sweep && adv && b_v_r && (b_l_r != '0);
  assign sweep_done = sweep && !a_v_r && !b_v_r && (k_r == KW'(NUM_SYMBOLS));
  assign out_load   = (state_r == chc_pkg::ST_EMIT) && adv && b_v_r;

  assign pref_issue = (state_r == chc_pkg::ST_PREF) && (j_r < LW'(MAX_LEN - 1));
  assign pref_done  = (state_r == chc_pkg::ST_PREF) && !pref_issue && !p_v_r;
  assign pref_sum   = code_r + tab_q;
  assign pref_code  = {pref_sum[CW-2:0], 1'b0};
  assign p_j_inc    = p_j_r + LW'(1);

  always_comb begin
    tab_req   = '0;
    state_nxt = state_r;
    case (state_r)
      chc_pkg::ST_LOAD: begin
        if (in_fire && in_ch.last) begin
          state_nxt = chc_pkg::ST_HIST;
        end
      end
      chc_pkg::ST_HIST, chc_pkg::ST_EMIT: begin
        tab_req.rd_en   = adv && a_v_r;
        tab_req.rd_addr = st_q;
        tab_req.wr_en   = sweep_wr;
        tab_req.wr_addr = b_l_r;
        tab_req.wr_data = tab_inc;
        if (sweep_done) begin
          if (state_r == chc_pkg::ST_HIST) begin
            state_nxt = chc_pkg::ST_PREF;
          end else begin
            tab_req.clr = 1'b1;
            state_nxt   = chc_pkg::ST_LOAD;
          end
        end
      end
      chc_pkg::ST_PREF: begin
        tab_req.rd_en   = pref_issue;
        tab_req.rd_addr = LEN_W'(j_r);
        tab_req.wr_en   = p_v_r;
        tab_req.wr_addr = LEN_W'(p_j_inc);
        tab_req.wr_data = pref_code;
        if (pref_done) begin
          state_nxt = chc_pkg::ST_EMIT;
        end
      end
      default: begin
        state_nxt = chc_pkg::ST_LOAD;
      end
    endcase
  end

  assign phase_chg = (state_nxt != state_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chc_pkg::ST_LOAD;
      st_vld_r    <= '0;
      st_qv_r     <= 1'b0;
      k_r         <= '0;
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      lw_en_r     <= 1'b0;
      j_r         <= '0;
      p_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (tab_req.clr) begin
        st_vld_r <= '0;
      end else if (ld_en) begin
        st_vld_r[ld_idx] <= 1'b1;
      end
      if (issue) begin
        st_qv_r <= st_vld_r[k_r[SW-1:0]];
      end

      if (phase_chg) begin
        k_r     <= '0;
        a_v_r   <= 1'b0;
        b_v_r   <= 1'b0;
        lw_en_r <= 1'b0;
        j_r     <= '0;
        p_v_r   <= 1'b0;
      end else begin
        if (issue) begin
          k_r <= k_r + KW'(1);
        end
        if (sweep && adv) begin
          a_v_r   <= issue;
          b_v_r   <= a_v_r;
          lw_en_r <= sweep_wr;
        end
        if (pref_issue) begin
          j_r <= j_r + LW'(1);
        end
        p_v_r <= pref_issue;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_en) begin
      st_mem[ld_idx] <= ld_len;
    end
    if (issue) begin
      st_q_r <= st_mem[k_r[SW-1:0]];
      a_k_r  <= k_r[SW-1:0];
    end
    if (sweep && adv) begin
      b_k_r     <= a_k_r;
      b_l_r     <= st_q;
      lw_addr_r <= b_l_r;
      lw_data_r <= tab_inc;
    end
    if (phase_chg) begin
      code_r <= '0;
    end else if (p_v_r) begin
      code_r <= pref_code;
    end
    p_j_r <= j_r;
    if (out_load) begin
      out_k_r     <= b_k_r;
      out_code_r  <= (b_l_r != '0) ? tab_d : '0;
      out_len_r   <= b_l_r;
      out_final_r <= (b_k_r == SW'(NUM_SYMBOLS - 1));
    end
  end

  assign out_sym_ext       = 7'(out_k_r);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_symbol = out_sym_ext[chc_pkg::SYM_W-1:0];
  assign out_ch.code_bits  = out_code_r;
  assign out_ch.out_length = out_len_r;
  assign out_ch.final_item = out_final_r;

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == chc_pkg::ST_LOAD) |-> (!a_v_r && !b_v_r && !p_v_r))
    else $error("build pipeline busy while loading");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten");

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.last) |=> (state_r == chc_pkg::ST_HIST))
    else $error("last item did not start the build");

  a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (b_k_r == SW'(NUM_SYMBOLS - 1))) |=> (state_r == chc_pkg::ST_EMIT))
    else $error("emission left before the final item");

endmodule

`default_nettype wire
